>>> design/cga_pkg.sv
// Shared types and constants for the channel grant allocator.
// No dependencies; the pool, the top and the testbench use it by scoped names.
package cga_pkg;

   localparam int CHAN_W  = 12;
   localparam int GROUP_W = 24;
   localparam int LEASE_W = 26;
   localparam int ACT_W   = 3;
   localparam int COUNT_W = 5;

   localparam logic [31:0]        MS_PER_S = 32'd1000;
   localparam logic [LEASE_W-1:0] AGE_MAX  = {LEASE_W{1'b1}};

   localparam logic [ACT_W-1:0] ACT_ADD     = 3'd0;
   localparam logic [ACT_W-1:0] ACT_GRANT   = 3'd1;
   localparam logic [ACT_W-1:0] ACT_TOUCH   = 3'd2;
   localparam logic [ACT_W-1:0] ACT_RELEASE = 3'd3;
   localparam logic [ACT_W-1:0] ACT_REL_ALL = 3'd4;
   localparam logic [ACT_W-1:0] ACT_TICK    = 3'd5;
   localparam logic [ACT_W-1:0] ACT_QGROUP  = 3'd6;
   localparam logic [ACT_W-1:0] ACT_QCHAN   = 3'd7;

   typedef struct packed {
      logic [GROUP_W-1:0] group;
      logic [CHAN_W-1:0]  chan;
      logic [LEASE_W-1:0] lease;
      logic [LEASE_W-1:0] age;
   } grant_entry_type;

   typedef struct packed {
      logic              push;
      logic              pop;
      logic [CHAN_W-1:0] chan;
   } pool_cmd_type;

endpackage

>>> design/cga_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module cga_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

>>> design/cga_pool.sv
// Free channel pool: circular FIFO of channel numbers held in a cga_ram.
// Depends on cga_pkg and cga_ram. Head entry is read every cycle.
module cga_pool #(
   parameter int POOL_DEPTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  cga_pkg::pool_cmd_type              cmd,
   output logic [cga_pkg::CHAN_W-1:0]         head_chan,
   output logic [$clog2(POOL_DEPTH+1)-1:0]    fill
);

   localparam int PW  = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int PCW = $clog2(POOL_DEPTH + 1);

   logic [PW-1:0]  head_ff, head_in;
   logic [PCW-1:0] fill_ff, fill_in;
   logic [PW:0]    tail_sum;
   logic [PW:0]    tail_wrap;
   logic           wr_en;

   assign tail_sum  = (PW+1)'(head_ff) + (PW+1)'(fill_ff);
   assign tail_wrap = (tail_sum >= (PW+1)'(POOL_DEPTH)) ?
                      tail_sum - (PW+1)'(POOL_DEPTH) : tail_sum;
   // drop a push when the pool is full
   assign wr_en = cmd.push && (fill_ff < PCW'(POOL_DEPTH));

   always_comb begin
      head_in = head_ff;
      fill_in = fill_ff;
      if (wr_en) begin
         fill_in = fill_ff + PCW'(1);
      end else if (cmd.pop && fill_ff != '0) begin
         fill_in = fill_ff - PCW'(1);
         head_in = (head_ff == PW'(POOL_DEPTH - 1)) ? '0 : head_ff + PW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         fill_ff <= fill_in;
      end
   end

   cga_ram #(
      .WIDTH (cga_pkg::CHAN_W),
      .DEPTH (POOL_DEPTH)
   ) u_pool_ram (
      .clock (clock),
      .we    (wr_en),
      .waddr (tail_wrap[PW-1:0]),
      .wdata (cmd.chan),
      .raddr (head_ff),
      .rdata (head_chan)
   );

   assign fill = fill_ff;

endmodule

>>> design/channel_grant_allocator_unit.sv
// Channel grant allocator top: command sequencer and grant table memory.
// Depends on cga_pkg, cga_ram and cga_pool.
//
//  channel   | handshake              | ports
//  ----------+------------------------+-------------------------------------------
//  request   | start high, busy low   | req_action req_dst_id req_channel ...
//  response  | rsp_valid, one cycle   | rsp_ok rsp_granted_channel rsp_busy_res ...
//
// Add channel answers without a table walk. Grant, touch, release and queries
// walk the grant table once through its single read port. Release all walks it
// to find the lowest marked destination; tick walks it to age the grants and
// then as release all; each released grant adds a walk for the next lowest one.
// Synchronous reset clears the state, valid, mark and grant count registers and
// the pool pointers, not the memories. The receiver cannot stall the response.
module channel_grant_allocator_unit #(
   parameter int POOL_DEPTH  = 16,
   parameter int GRANT_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_action,
   input  logic [23:0] req_dst_id,
   input  logic [11:0] req_channel,
   input  logic [15:0] req_timeout_s,
   input  logic [15:0] req_elapsed_ms,
   output logic        rsp_valid,
   output logic        rsp_ok,
   output logic [11:0] rsp_granted_channel,
   output logic        rsp_busy_res,
   output logic [4:0]  rsp_released_count,
   output logic [4:0]  rsp_grant_count,
   output logic [4:0]  rsp_free_count
);

   localparam int SW  = (GRANT_SLOTS > 1) ? $clog2(GRANT_SLOTS) : 1;
   localparam int CW  = $clog2(GRANT_SLOTS + 1);
   localparam int PCW = $clog2(POOL_DEPTH + 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_FIN    = 3'd2;
   localparam logic [2:0] S_MIN    = 3'd3;
   localparam logic [2:0] S_MINFIN = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0]                     state_ff, state_in;
   logic [cga_pkg::ACT_W-1:0]      act_ff, act_in;
   logic [cga_pkg::GROUP_W-1:0]    dst_ff, dst_in;
   logic [cga_pkg::CHAN_W-1:0]     chn_ff, chn_in;
   logic [cga_pkg::LEASE_W-1:0]    lease_ff, lease_in;
   logic [15:0]                    ms_ff, ms_in;
   logic [CW-1:0]                  scan_ff, scan_in;
   logic                           pv_ff, pv_in;
   logic [SW-1:0]                  pi_ff, pi_in;
   logic                           hit_ff, hit_in;
   logic [SW-1:0]                  hit_idx_ff, hit_idx_in;
   cga_pkg::grant_entry_type       hit_ent_ff, hit_ent_in;
   logic                           free_ok_ff, free_ok_in;
   logic [SW-1:0]                  free_idx_ff, free_idx_in;
   logic                           best_ff, best_in;
   logic [SW-1:0]                  best_idx_ff, best_idx_in;
   logic [cga_pkg::GROUP_W-1:0]    best_grp_ff, best_grp_in;
   logic [cga_pkg::CHAN_W-1:0]     best_chan_ff, best_chan_in;
   logic [GRANT_SLOTS-1:0]         valid_ff, valid_in;
   logic [GRANT_SLOTS-1:0]         mark_ff, mark_in;
   logic [CW-1:0]                  active_ff, active_in;
   logic [CW-1:0]                  rel_ff, rel_in;
   logic                           ok_ff, ok_in;
   logic [cga_pkg::CHAN_W-1:0]     gch_ff, gch_in;
   logic                           busyr_ff, busyr_in;

   logic                           tab_we;
   logic [SW-1:0]                  tab_waddr;
   cga_pkg::grant_entry_type       tab_wdata;
   cga_pkg::grant_entry_type       tab_rdata;
   cga_pkg::pool_cmd_type          pcmd;
   logic [cga_pkg::CHAN_W-1:0]     pool_head_chan;
   logic [PCW-1:0]                 pool_fill;

   logic                           scan_go;
   logic                           scan_last;
   logic                           cur_valid;
   logic [cga_pkg::LEASE_W:0]      age_sum;
   logic [cga_pkg::LEASE_W-1:0]    age_new;
   logic [31:0]                    act32, fill32, rel32;

   assign scan_go   = scan_ff < CW'(GRANT_SLOTS);
   assign scan_last = pv_ff && (pi_ff == SW'(GRANT_SLOTS - 1));
   assign cur_valid = valid_ff[pi_ff];
   assign age_sum   = {1'b0, tab_rdata.age} + (cga_pkg::LEASE_W+1)'(ms_ff);
   assign age_new   = age_sum[cga_pkg::LEASE_W] ? cga_pkg::AGE_MAX :
                      age_sum[cga_pkg::LEASE_W-1:0];

   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      dst_in       = dst_ff;
      chn_in       = chn_ff;
      lease_in     = lease_ff;
      ms_in        = ms_ff;
      scan_in      = scan_ff;
      pv_in        = pv_ff;
      pi_in        = pi_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_ent_in   = hit_ent_ff;
      free_ok_in   = free_ok_ff;
      free_idx_in  = free_idx_ff;
      best_in      = best_ff;
      best_idx_in  = best_idx_ff;
      best_grp_in  = best_grp_ff;
      best_chan_in = best_chan_ff;
      valid_in     = valid_ff;
      mark_in      = mark_ff;
      active_in    = active_ff;
      rel_in       = rel_ff;
      ok_in        = ok_ff;
      gch_in       = gch_ff;
      busyr_in     = busyr_ff;
      tab_we       = 1'b0;
      tab_waddr    = pi_ff;
      tab_wdata    = tab_rdata;
      pcmd         = '0;

      // walk the table: issue one read a cycle, evaluate it the next
      if (state_ff == S_SCAN || state_ff == S_MIN) begin
         if (scan_go) begin
            scan_in = scan_ff + CW'(1);
            pv_in   = 1'b1;
            pi_in   = scan_ff[SW-1:0];
         end else begin
            pv_in = 1'b0;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               act_in     = req_action;
               dst_in     = req_dst_id;
               chn_in     = req_channel;
               lease_in   = cga_pkg::LEASE_W'(32'(req_timeout_s) * cga_pkg::MS_PER_S);
               ms_in      = req_elapsed_ms;
               scan_in    = '0;
               pv_in      = 1'b0;
               hit_in     = 1'b0;
               free_ok_in = 1'b0;
               best_in    = 1'b0;
               rel_in     = '0;
               ok_in      = 1'b0;
               gch_in     = '0;
               busyr_in   = 1'b0;
               mark_in    = '0;
               case (req_action)
                  cga_pkg::ACT_ADD: begin
                     if (req_channel != '0 &&
                         (32'(pool_fill) + 32'(active_ff)) < 32'(POOL_DEPTH)) begin
                        pcmd.push = 1'b1;
                        pcmd.chan = req_channel;
                        ok_in     = 1'b1;
                     end
                     state_in = S_DONE;
                  end
                  cga_pkg::ACT_REL_ALL: begin
                     mark_in  = valid_ff;
                     state_in = S_MIN;
                  end
                  default: begin
                     state_in = S_SCAN;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (pv_ff) begin
               case (act_ff)
                  cga_pkg::ACT_TICK: begin
                     if (cur_valid) begin
                        tab_we        = 1'b1;
                        tab_wdata.age = age_new;
                        if (tab_rdata.lease != '0 && age_new >= tab_rdata.lease) begin
                           mark_in[pi_ff] = 1'b1;
                        end
                     end
                  end
                  cga_pkg::ACT_QCHAN: begin
                     if (cur_valid && chn_ff != '0 && tab_rdata.chan == chn_ff) begin
                        busyr_in = 1'b1;
                     end
                  end
                  default: begin
                     if (cur_valid && tab_rdata.group == dst_ff) begin
                        hit_in     = 1'b1;
                        hit_idx_in = pi_ff;
                        hit_ent_in = tab_rdata;
                     end
                     if (!cur_valid && !free_ok_ff) begin
                        free_ok_in  = 1'b1;
                        free_idx_in = pi_ff;
                     end
                  end
               endcase
            end
            if (scan_last) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            state_in = S_DONE;
            case (act_ff)
               cga_pkg::ACT_GRANT: begin
                  if (dst_ff != '0 && pool_fill != '0 && !hit_ff && free_ok_ff) begin
                     pcmd.pop        = 1'b1;
                     tab_we          = 1'b1;
                     tab_waddr       = free_idx_ff;
                     tab_wdata.group = dst_ff;
                     tab_wdata.chan  = pool_head_chan;
                     tab_wdata.lease = lease_ff;
                     tab_wdata.age   = '0;
                     valid_in[free_idx_ff] = 1'b1;
                     active_in       = active_ff + CW'(1);
                     ok_in           = 1'b1;
                     gch_in          = pool_head_chan;
                  end
               end
               cga_pkg::ACT_TOUCH: begin
                  if (dst_ff != '0 && hit_ff) begin
                     tab_we        = 1'b1;
                     tab_waddr     = hit_idx_ff;
                     tab_wdata     = hit_ent_ff;
                     tab_wdata.age = '0;
                     ok_in         = 1'b1;
                  end
               end
               cga_pkg::ACT_RELEASE: begin
                  if (dst_ff != '0 && hit_ff) begin
                     pcmd.push            = 1'b1;
                     pcmd.chan            = hit_ent_ff.chan;
                     valid_in[hit_idx_ff] = 1'b0;
                     active_in            = active_ff - CW'(1);
                     rel_in               = CW'(1);
                     ok_in                = 1'b1;
                  end
               end
               cga_pkg::ACT_QGROUP: begin
                  if (dst_ff != '0) begin
                     ok_in = 1'b1;
                     if (hit_ff) begin
                        busyr_in = 1'b1;
                        gch_in   = hit_ent_ff.chan;
                     end
                  end
               end
               cga_pkg::ACT_TICK: begin
                  scan_in  = '0;
                  pv_in    = 1'b0;
                  best_in  = 1'b0;
                  state_in = S_MIN;
               end
               default: begin
                  ok_in = 1'b1;
               end
            endcase
         end
         S_MIN: begin
            if (pv_ff && mark_ff[pi_ff] && cur_valid &&
                (!best_ff || tab_rdata.group < best_grp_ff)) begin
               best_in      = 1'b1;
               best_idx_in  = pi_ff;
               best_grp_in  = tab_rdata.group;
               best_chan_in = tab_rdata.chan;
            end
            if (scan_last) begin
               state_in = S_MINFIN;
            end
         end
         S_MINFIN: begin
            if (best_ff) begin
               // release the lowest marked destination, then search again
               pcmd.push             = 1'b1;
               pcmd.chan             = best_chan_ff;
               valid_in[best_idx_ff] = 1'b0;
               mark_in[best_idx_ff]  = 1'b0;
               active_in             = active_ff - CW'(1);
               rel_in                = rel_ff + CW'(1);
               best_in               = 1'b0;
               scan_in               = '0;
               pv_in                 = 1'b0;
               state_in              = S_MIN;
            end else begin
               ok_in    = (act_ff == cga_pkg::ACT_REL_ALL) || (rel_ff != '0);
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         valid_ff  <= '0;
         mark_ff   <= '0;
         active_ff <= '0;
         pv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         valid_ff  <= valid_in;
         mark_ff   <= mark_in;
         active_ff <= active_in;
         pv_ff     <= pv_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff       <= act_in;
      dst_ff       <= dst_in;
      chn_ff       <= chn_in;
      lease_ff     <= lease_in;
      ms_ff        <= ms_in;
      scan_ff      <= scan_in;
      pi_ff        <= pi_in;
      hit_ff       <= hit_in;
      hit_idx_ff   <= hit_idx_in;
      hit_ent_ff   <= hit_ent_in;
      free_ok_ff   <= free_ok_in;
      free_idx_ff  <= free_idx_in;
      best_ff      <= best_in;
      best_idx_ff  <= best_idx_in;
      best_grp_ff  <= best_grp_in;
      best_chan_ff <= best_chan_in;
      rel_ff       <= rel_in;
      ok_ff        <= ok_in;
      gch_ff       <= gch_in;
      busyr_ff     <= busyr_in;
   end

   cga_ram #(
      .WIDTH ($bits(cga_pkg::grant_entry_type)),
      .DEPTH (GRANT_SLOTS)
   ) u_grant_ram (
      .clock (clock),
      .we    (tab_we),
      .waddr (tab_waddr),
      .wdata (tab_wdata),
      .raddr (scan_ff[SW-1:0]),
      .rdata (tab_rdata)
   );

   cga_pool #(
      .POOL_DEPTH (POOL_DEPTH)
   ) u_pool (
      .clock     (clock),
      .reset     (reset),
      .cmd       (pcmd),
      .head_chan (pool_head_chan),
      .fill      (pool_fill)
   );

   assign act32  = 32'(active_ff);
   assign fill32 = 32'(pool_fill);
   assign rel32  = 32'(rel_ff);

   assign busy                = (state_ff != S_IDLE);
   assign rsp_valid           = (state_ff == S_DONE);
   assign rsp_ok              = ok_ff;
   assign rsp_granted_channel = gch_ff;
   assign rsp_busy_res        = busyr_ff;
   assign rsp_released_count  = (rel32 > 32'd31) ? 5'd31 : rel32[4:0];
   assign rsp_grant_count     = (act32 > 32'd31) ? 5'd31 : act32[4:0];
   assign rsp_free_count      = (fill32 > 32'd31) ? 5'd31 : fill32[4:0];

endmodule

>>> verif/channel_grant_allocator_unit_tb.sv
// Testbench for channel_grant_allocator_unit: directed and random commands
// checked against a behavioral allocator model. Depends on cga_pkg and the RTL.
`timescale 1ns / 1ps

module channel_grant_allocator_unit_tb;

   localparam int POOL_N  = 16;
   localparam int SLOT_N  = 16;
   localparam int IDLE_LIMIT = 5000;

   typedef struct packed {
      logic [2:0]  action;
      logic [23:0] dst_id;
      logic [11:0] channel;
      logic [15:0] timeout_s;
      logic [15:0] elapsed_ms;
   } cmd_word_type;

   typedef struct packed {
      logic        ok;
      logic [11:0] gch;
      logic        busy_res;
      logic [4:0]  released;
      logic [4:0]  grants;
      logic [4:0]  frees;
   } rsp_word_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [2:0]  req_action = '0;
   logic [23:0] req_dst_id = '0;
   logic [11:0] req_channel = '0;
   logic [15:0] req_timeout_s = '0;
   logic [15:0] req_elapsed_ms = '0;
   logic        rsp_valid, rsp_ok, rsp_busy_res;
   logic [11:0] rsp_granted_channel;
   logic [4:0]  rsp_released_count, rsp_grant_count, rsp_free_count;

   channel_grant_allocator_unit u_top (.*);

   // allocator model state
   logic [11:0] pool_mem [POOL_N];
   int unsigned pool_rd, pool_cnt, grant_cnt;
   logic        slot_used [SLOT_N];
   logic [23:0] slot_group [SLOT_N];
   logic [11:0] slot_chan [SLOT_N];
   logic [25:0] slot_lease [SLOT_N];
   logic [25:0] slot_age [SLOT_N];

   cmd_word_type cmd_queue [$];
   rsp_word_type expected_rsps [$];
   int  send_idle_pct = 32;
   bit  failed = 0;
   int  idle_cycles = 0;
   logic [23:0] groups [8];

   function automatic void queue_cmd(cmd_word_type c);
      cmd_queue.insert(cmd_queue.size(), c);
   endfunction

   function automatic int find_group(logic [23:0] g);
      for (int s = 0; s < SLOT_N; s++)
         if (slot_used[s] && slot_group[s] == g) return s;
      return -1;
   endfunction

   function automatic void return_slot(int s);
      if (pool_cnt < POOL_N) begin
         pool_mem[(pool_rd + pool_cnt) % POOL_N] = slot_chan[s];
         pool_cnt++;
      end
      slot_used[s] = 0;
      if (grant_cnt > 0) grant_cnt--;
   endfunction

   // free marked slots, lowest destination first
   function automatic int unsigned release_lowest_first(logic mark [SLOT_N]);
      int unsigned n = 0;
      int best;
      forever begin
         best = -1;
         for (int s = 0; s < SLOT_N; s++)
            if (mark[s] && slot_used[s] &&
                (best < 0 || slot_group[s] < slot_group[best])) best = s;
         if (best < 0) break;
         mark[best] = 0;
         return_slot(best);
         n++;
      end
      return n;
   endfunction

   function automatic rsp_word_type allocate_step(cmd_word_type c);
      rsp_word_type r;
      logic mark [SLOT_N];
      int s, f;
      logic [26:0] sum;
      r = '0;
      case (c.action)
         cga_pkg::ACT_ADD: if (c.channel != 0 && pool_cnt + grant_cnt < POOL_N) begin
            pool_mem[(pool_rd + pool_cnt) % POOL_N] = c.channel;
            pool_cnt++;
            r.ok = 1;
         end
         cga_pkg::ACT_GRANT: if (c.dst_id != 0 && pool_cnt > 0 &&
                                 find_group(c.dst_id) < 0) begin
            f = -1;
            for (s = SLOT_N - 1; s >= 0; s--) if (!slot_used[s]) f = s;
            if (f >= 0) begin
               slot_chan[f] = pool_mem[pool_rd];
               pool_rd = (pool_rd + 1) % POOL_N;
               pool_cnt--;
               slot_used[f] = 1;
               slot_group[f] = c.dst_id;
               slot_lease[f] = 26'(32'(c.timeout_s) * 1000);
               slot_age[f] = '0;
               grant_cnt++;
               r.ok = 1;
               r.gch = slot_chan[f];
            end
         end
         cga_pkg::ACT_TOUCH: if (c.dst_id != 0) begin
            s = find_group(c.dst_id);
            if (s >= 0) begin
               slot_age[s] = '0;
               r.ok = 1;
            end
         end
         cga_pkg::ACT_RELEASE: if (c.dst_id != 0) begin
            s = find_group(c.dst_id);
            if (s >= 0) begin
               return_slot(s);
               r.released = 1;
               r.ok = 1;
            end
         end
         cga_pkg::ACT_REL_ALL: begin
            for (s = 0; s < SLOT_N; s++) mark[s] = slot_used[s];
            r.released = 5'(release_lowest_first(mark));
            r.ok = 1;
         end
         cga_pkg::ACT_TICK: begin
            for (s = 0; s < SLOT_N; s++) begin
               mark[s] = 0;
               if (slot_used[s]) begin
                  sum = 27'(slot_age[s]) + 27'(c.elapsed_ms);
                  slot_age[s] = sum > 27'(cga_pkg::AGE_MAX) ? cga_pkg::AGE_MAX : sum[25:0];
                  if (slot_lease[s] != 0 && slot_age[s] >= slot_lease[s]) mark[s] = 1;
               end
            end
            r.released = 5'(release_lowest_first(mark));
            r.ok = r.released != 0;
         end
         cga_pkg::ACT_QGROUP: if (c.dst_id != 0) begin
            r.ok = 1;
            s = find_group(c.dst_id);
            if (s >= 0) begin
               r.busy_res = 1;
               r.gch = slot_chan[s];
            end
         end
         default: begin
            r.ok = 1;
            if (c.channel != 0)
               for (s = 0; s < SLOT_N; s++)
                  if (slot_used[s] && slot_chan[s] == c.channel) r.busy_res = 1;
         end
      endcase
      r.grants = 5'(grant_cnt);
      r.frees = 5'(pool_cnt);
      return r;
   endfunction

   function automatic cmd_word_type make_cmd(logic [2:0] a, logic [23:0] d, logic [11:0] ch,
                                             logic [15:0] t, logic [15:0] ms);
      cmd_word_type c;
      c.action = a; c.dst_id = d; c.channel = ch; c.timeout_s = t; c.elapsed_ms = ms;
      return c;
   endfunction

   // mostly a small set of groups and short leases so grants, expiry and refusals recur
   function automatic cmd_word_type random_cmd();
      cmd_word_type c;
      int p = $urandom_range(99);
      c = make_cmd(3'($urandom_range(7)), 24'($urandom), 12'($urandom), 16'($urandom),
                   16'($urandom));
      if (p < 85) begin
         c.dst_id = groups[$urandom_range(7)];
         if ($urandom_range(9) == 0) c.dst_id = '0;
         c.channel = 12'($urandom_range(1, 40));
         c.timeout_s = 16'($urandom_range(0, 4));
         c.elapsed_ms = 16'($urandom_range(0, 2500));
         p = $urandom_range(99);
         c.action = p < 22 ? cga_pkg::ACT_ADD : p < 45 ? cga_pkg::ACT_GRANT :
                    p < 52 ? cga_pkg::ACT_TOUCH : p < 62 ? cga_pkg::ACT_RELEASE :
                    p < 65 ? cga_pkg::ACT_REL_ALL : p < 82 ? cga_pkg::ACT_TICK :
                    p < 91 ? cga_pkg::ACT_QGROUP : cga_pkg::ACT_QCHAN;
      end
      return c;
   endfunction

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;
   end

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            expected_rsps.insert(expected_rsps.size(), allocate_step(cmd_queue.pop_front()));
         end
         if (cmd_queue.size() > 0) begin
            if (!(start && busy)) begin
               if ($urandom_range(99) < send_idle_pct) start <= 0;
               else begin
                  start <= 1;
                  {req_action, req_dst_id, req_channel, req_timeout_s, req_elapsed_ms}
                     <= cmd_queue[0];
               end
            end
         end else if (!(start && busy)) start <= 0;
      end
   end

   // monitor
   always @(posedge clock) begin : monitor_blk
      rsp_word_type e;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $error("response with nothing expected");
            failed = 1;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_ok !== e.ok) begin
               $error("ok exp %0d got %0d", e.ok, rsp_ok); failed = 1;
            end
            if (rsp_granted_channel !== e.gch) begin
               $error("granted_channel exp %0d got %0d", e.gch, rsp_granted_channel);
               failed = 1;
            end
            if (rsp_busy_res !== e.busy_res) begin
               $error("busy_res exp %0d got %0d", e.busy_res, rsp_busy_res); failed = 1;
            end
            if (rsp_released_count !== e.released) begin
               $error("released_count exp %0d got %0d", e.released, rsp_released_count);
               failed = 1;
            end
            if (rsp_grant_count !== e.grants) begin
               $error("grant_count exp %0d got %0d", e.grants, rsp_grant_count);
               failed = 1;
            end
            if (rsp_free_count !== e.frees) begin
               $error("free_count exp %0d got %0d", e.frees, rsp_free_count);
               failed = 1;
            end
         end
      end
   end

   // watchdog: count cycles with no word accepted on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      for (int s = 0; s < SLOT_N; s++) slot_used[s] = 0;
      pool_rd = 0; pool_cnt = 0; grant_cnt = 0;
      groups[0] = 24'd1; groups[1] = 24'hFFFFFF; groups[2] = 24'h800000;
      groups[3] = 24'h5; groups[4] = 24'h7; groups[5] = 24'h123456;
      groups[6] = 24'h2; groups[7] = 24'hAAAAAA;
      // directed: refusals, extremes, expiry, lease that never ends
      queue_cmd(make_cmd(cga_pkg::ACT_GRANT, 24'd1, 12'd0, 16'd1, 16'd0));
      queue_cmd(make_cmd(cga_pkg::ACT_ADD, 24'd0, 12'd0, 16'd0, 16'd0));
      queue_cmd(make_cmd(cga_pkg::ACT_ADD, 24'd0, 12'hFFF, 16'd0, 16'd0));
      queue_cmd(make_cmd(cga_pkg::ACT_ADD, 24'd0, 12'd1, 16'd0, 16'd0));
      queue_cmd(make_cmd(cga_pkg::ACT_ADD, 24'd0, 12'h555, 16'd0, 16'd0));
      queue_cmd(make_cmd(cga_pkg::ACT_GRANT, 24'd0, 12'd0, 16'd1, 16'd0));
      queue_cmd(make_cmd(cga_pkg::ACT_GRANT, 24'hFFFFFF, 12'd0, 16'hFFFF, 16'd0));
      queue_cmd(make_cmd(cga_pkg::ACT_GRANT, 24'hFFFFFF, 12'd0, 16'd1, 16'd0));
      queue_cmd(make_cmd(cga_pkg::ACT_GRANT, 24'd3, 12'd0, 16'd0, 16'd0));
      queue_cmd(make_cmd(cga_pkg::ACT_GRANT, 24'd2, 12'd0, 16'd1, 16'd0));
      queue_cmd(make_cmd(cga_pkg::ACT_QGROUP, 24'd0, 12'd0, 16'd0, 16'd0));
      queue_cmd(make_cmd(cga_pkg::ACT_QGROUP, 24'hFFFFFF, 12'd0, 16'd0, 16'd0));
      queue_cmd(make_cmd(cga_pkg::ACT_QCHAN, 24'd0, 12'hFFF, 16'd0, 16'd0));
      queue_cmd(make_cmd(cga_pkg::ACT_QCHAN, 24'd0, 12'd0, 16'd0, 16'd0));
      queue_cmd(make_cmd(cga_pkg::ACT_TOUCH, 24'd0, 12'd0, 16'd0, 16'd0));
      queue_cmd(make_cmd(cga_pkg::ACT_TOUCH, 24'd2, 12'd0, 16'd0, 16'd0));
      queue_cmd(make_cmd(cga_pkg::ACT_TICK, 24'd0, 12'd0, 16'd0, 16'd999));
      queue_cmd(make_cmd(cga_pkg::ACT_TICK, 24'd0, 12'd0, 16'd0, 16'hFFFF));
      for (int i = 0; i < 4; i++)
         queue_cmd(make_cmd(cga_pkg::ACT_TICK, 24'd0, 12'd0, 16'd0, 16'hFFFF));
      queue_cmd(make_cmd(cga_pkg::ACT_RELEASE, 24'd0, 12'd0, 16'd0, 16'd0));
      queue_cmd(make_cmd(cga_pkg::ACT_RELEASE, 24'hFFFFFF, 12'd0, 16'd0, 16'd0));
      queue_cmd(make_cmd(cga_pkg::ACT_REL_ALL, 24'd0, 12'd0, 16'd0, 16'd0));
      queue_cmd(make_cmd(cga_pkg::ACT_REL_ALL, 24'd0, 12'd0, 16'd0, 16'd0));
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = phase == 0 ? 32 : phase == 1 ? 69 : 0;
         for (int i = 0; i < 510; i++) queue_cmd(random_cmd());
         wait (cmd_queue.size() == 0);
      end
      wait (expected_rsps.size() == 0);
      repeat (400) @(posedge clock);
      if (!failed && expected_rsps.size() == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end
endmodule
